// File: hdl/smx_pkg.sv
// Package for the softmax argmax block: sizes, constants, FSM type and the
// 2^(-f/256) table built at elaboration. No dependencies.

package smx_pkg;

   localparam int MAX_CLASSES = 64;
   localparam int ADDR_W      = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int CNT_W       = $clog2(MAX_CLASSES + 1);

   localparam int LOGIT_W = 16;
   localparam int CLASS_W = 6;
   localparam int CONF_W  = 16;
   localparam int EXP_W   = 17;
   localparam int T_W     = 17;
   localparam int PROD_W  = LOGIT_W + T_W;
   localparam int SUM_W   = EXP_W + CNT_W;

   localparam logic [T_W-1:0] LOG2E_Q16 = 17'd94548;

   // 2^32 / sum with sum >= 2^16: quotient fits in 17 bits
   localparam int QUO_W     = 17;
   localparam int STEP_W    = 5;
   localparam int DIV_STEPS = QUO_W;
   localparam logic [SUM_W:0] DIV_REM_INIT = (SUM_W + 1)'(32768);
   localparam logic [CONF_W-1:0] CONF_SAT = '1;

   typedef enum logic [3:0] {
      ST_LOAD = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   typedef logic [EXP_W-1:0] exp2_table_type [256];

   localparam logic [63:0] HALF_Q62 = 64'h2000_0000_0000_0000;

   // true when ((2y-1)/2^17)^256 <= 2^-f
   function automatic logic half_step_below(input logic [16:0] y, input int f);
      logic [63:0]  m;
      logic [127:0] p;
      int           e;
      m = (64'(y) * 64'd2 - 64'd1) << 45;
      e = 0;
      for (int k = 0; k < 8; k++) begin
         p = {64'd0, m} * {64'd0, m};
         m = p[125:62];
         e = e * 2;
         for (int j = 0; j < 2; j++) begin
            if (m < HALF_Q62) begin
               m = m << 1;
               e = e - 1;
            end
         end
      end
      return (e <= -f) || ((e == 1 - f) && (m == HALF_Q62));
   endfunction

   function automatic exp2_table_type build_exp2_table();
      exp2_table_type tbl;
      logic [16:0]    lo;
      logic [16:0]    hi;
      logic [16:0]    mid;
      tbl[0] = 17'd65536;
      for (int f = 1; f < 256; f++) begin
         lo = 17'd32769;
         hi = 17'd65536;
         for (int it = 0; it < 16; it++) begin
            if (hi - lo > 17'd1) begin
               mid = (lo + hi) >> 1;
               if (half_step_below(mid, f)) begin
                  lo = mid;
               end else begin
                  hi = mid;
               end
            end
         end
         tbl[f] = lo;
      end
      return tbl;
   endfunction

   localparam exp2_table_type EXP2_TABLE = build_exp2_table();

endpackage

// File: hdl/softmax_argmax_confidence.sv
// Softmax argmax with confidence: score store, scan sequencer, exp unit and
// divider. Depends on smx_pkg, smx_ram, smx_exp, smx_div.
//
//   channel  dir  transfer carries
//   req      in   one Q8.8 logit, last_element flag
//   rsp      out  class_index, confidence, overflow (one per vector)
//
// Loading: one logit per cycle while req_ready is high.
// After the last logit, the N stored scores are read through the RAM and the exp
// unit into the sum, the divider runs, then the result register is loaded.
// req_ready is low from the last logit until the result is loaded; a result
// waiting on rsp_ready holds only the next vector's end.
// Synchronous active-high reset; no memory clearing is needed.

module softmax_argmax_confidence (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [smx_pkg::LOGIT_W-1:0]  req_logit,
   input  logic                                req_last_element,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [smx_pkg::CLASS_W-1:0]         rsp_class_index,
   output logic [smx_pkg::CONF_W-1:0]          rsp_confidence,
   output logic                                rsp_overflow
);

   smx_pkg::state_type state_ff;
   smx_pkg::state_type state_in;

   logic [smx_pkg::CNT_W-1:0]          count_ff;
   logic signed [smx_pkg::LOGIT_W-1:0] max_ff;
   logic [smx_pkg::ADDR_W-1:0]         best_ff;
   logic                               dropped_ff;
   logic [smx_pkg::CNT_W-1:0]          scan_ff;
   logic                               rd_valid_ff;
   logic [smx_pkg::SUM_W-1:0]          sum_ff;
   logic                               rsp_valid_ff;
   logic [smx_pkg::CLASS_W-1:0]        rsp_class_ff;
   logic [smx_pkg::CONF_W-1:0]         rsp_conf_ff;
   logic                               rsp_ovf_ff;

   logic                               accept;
   logic                               room;
   logic                               issue;
   logic                               scan_end;
   logic                               load_rsp;
   logic signed [smx_pkg::LOGIT_W-1:0] rd_score;
   logic                               exp_valid;
   logic [smx_pkg::EXP_W-1:0]          exp_val;
   logic                               div_done;
   logic [smx_pkg::CONF_W-1:0]         div_quo;

   assign req_ready = (state_ff == smx_pkg::ST_LOAD);
   assign accept    = req_valid && req_ready;
   assign room      = (count_ff < smx_pkg::CNT_W'(smx_pkg::MAX_CLASSES));
   assign issue     = (state_ff == smx_pkg::ST_SCAN) && (scan_ff < count_ff);
   assign scan_end  = (state_ff == smx_pkg::ST_SCAN) && !issue && !rd_valid_ff && !exp_valid;
   assign load_rsp  = (state_ff == smx_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   smx_ram #(
      .WIDTH (smx_pkg::LOGIT_W),
      .DEPTH (smx_pkg::MAX_CLASSES)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && room),
      .wr_addr (count_ff[smx_pkg::ADDR_W-1:0]),
      .wr_data (req_logit),
      .rd_en   (issue),
      .rd_addr (scan_ff[smx_pkg::ADDR_W-1:0]),
      .rd_data (rd_score)
   );

   smx_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid_ff),
      .run_max   (max_ff),
      .score     (rd_score),
      .out_valid (exp_valid),
      .out_exp   (exp_val)
   );

   smx_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (scan_end),
      .divisor  (sum_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smx_pkg::ST_LOAD: begin
            if (accept && req_last_element) begin
               state_in = smx_pkg::ST_SCAN;
            end
         end
         smx_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = smx_pkg::ST_DIV;
            end
         end
         smx_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = smx_pkg::ST_DONE;
            end
         end
         smx_pkg::ST_DONE: begin
            if (load_rsp) begin
               state_in = smx_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = smx_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smx_pkg::ST_LOAD;
         count_ff     <= '0;
         max_ff       <= '0;
         best_ff      <= '0;
         dropped_ff   <= 1'b0;
         scan_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= issue;
         if (accept) begin
            if (room) begin
               count_ff <= count_ff + 1'b1;
               if ((count_ff == '0) || (req_logit > max_ff)) begin
                  max_ff  <= req_logit;
                  best_ff <= count_ff[smx_pkg::ADDR_W-1:0];
               end
            end else begin
               dropped_ff <= 1'b1;
            end
            if (req_last_element) begin
               scan_ff <= '0;
            end
         end else if (issue) begin
            scan_ff <= scan_ff + 1'b1;
         end
         if (load_rsp) begin
            count_ff   <= '0;
            max_ff     <= '0;
            best_ff    <= '0;
            dropped_ff <= 1'b0;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept && req_last_element) begin
         sum_ff <= '0;
      end else if (exp_valid) begin
         sum_ff <= sum_ff + smx_pkg::SUM_W'(exp_val);
      end
      if (load_rsp) begin
         rsp_class_ff <= smx_pkg::CLASS_W'(best_ff);
         rsp_conf_ff  <= div_quo;
         rsp_ovf_ff   <= dropped_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_class_index = rsp_class_ff;
   assign rsp_confidence  = rsp_conf_ff;
   assign rsp_overflow    = rsp_ovf_ff;

endmodule

// File: hdl/smx_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.

module smx_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/smx_exp.sv
// Two-stage exp(-(max - x)) unit: log2e multiply, then table lookup and shift.
// Depends on smx_pkg.

module smx_exp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [smx_pkg::LOGIT_W-1:0] run_max,
   input  logic signed [smx_pkg::LOGIT_W-1:0] score,
   output logic                              out_valid,
   output logic [smx_pkg::EXP_W-1:0]         out_exp
);

   logic signed [smx_pkg::LOGIT_W:0]  diff;
   logic [smx_pkg::LOGIT_W-1:0]       delta;
   logic [smx_pkg::PROD_W-1:0]        prod;
   logic [smx_pkg::T_W-1:0]           t_in;
   logic [smx_pkg::T_W-1:0]           t_ff;
   logic                              t_valid_ff;
   logic [8:0]                        int_part;
   logic [7:0]                        frac_part;

   assign diff  = {run_max[smx_pkg::LOGIT_W-1], run_max}
                - {score[smx_pkg::LOGIT_W-1], score};
   assign delta = diff[smx_pkg::LOGIT_W-1:0];
   assign prod  = smx_pkg::PROD_W'(delta) * smx_pkg::PROD_W'(smx_pkg::LOG2E_Q16);
   assign t_in  = prod[smx_pkg::PROD_W-1:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
      end else begin
         t_valid_ff <= in_valid;
      end
      t_ff <= t_in;
   end

   assign int_part  = t_ff[16:8];
   assign frac_part = t_ff[7:0];
   assign out_valid = t_valid_ff;
   assign out_exp   = (int_part >= 9'd17) ? '0
                    : (smx_pkg::EXP2_TABLE[frac_part] >> int_part[4:0]);

endmodule

// File: hdl/smx_div.sv
// Restoring divider, one quotient bit per cycle: 2^32 / divisor, saturated, zero for a zero divisor.
// Depends on smx_pkg.

module smx_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [smx_pkg::SUM_W-1:0]     divisor,
   output logic                          done,
   output logic [smx_pkg::CONF_W-1:0]    quotient
);

   logic [smx_pkg::SUM_W:0]    rem_ff;
   logic [smx_pkg::SUM_W:0]    rem_in;
   logic [smx_pkg::SUM_W:0]    shifted;
   logic [smx_pkg::SUM_W-1:0]  dvs_ff;
   logic [smx_pkg::QUO_W-1:0]  quo_ff;
   logic [smx_pkg::QUO_W-1:0]  quo_in;
   logic [smx_pkg::STEP_W-1:0] step_ff;
   logic                       run_ff;
   logic                       done_ff;
   logic                       zero_ff;

   assign shifted = {rem_ff[smx_pkg::SUM_W-1:0], 1'b0};

   always_comb begin
      if (shifted >= {1'b0, dvs_ff}) begin
         rem_in = shifted - {1'b0, dvs_ff};
         quo_in = {quo_ff[smx_pkg::QUO_W-2:0], 1'b1};
      end else begin
         rem_in = shifted;
         quo_in = {quo_ff[smx_pkg::QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == smx_pkg::STEP_W'(smx_pkg::DIV_STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         rem_ff  <= smx_pkg::DIV_REM_INIT;
         quo_ff  <= '0;
         dvs_ff  <= divisor;
         zero_ff <= (divisor == '0);
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = zero_ff ? '0 :
                     (quo_ff[smx_pkg::QUO_W-1] ? smx_pkg::CONF_SAT
                                               : quo_ff[smx_pkg::CONF_W-1:0]);

endmodule
